>>> hdl/latency_bucket_histogram_assert.svh
// ----------------------------------------------------------------------------
// Latency bucket histogram assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LATENCY_BUCKET_HISTOGRAM_ASSERT_SVH
`define LATENCY_BUCKET_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define LBH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("latency bucket histogram check failed");

// next-cycle implication
`define LBH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("latency bucket histogram check failed");

`endif

>>> hdl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// Latency bucket histogram package
// Sizes, opcodes, chain beat types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lbh_pkg;

    localparam int NUM_BOUNDS  = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BUCKETS = NUM_BOUNDS + 1;
    localparam int NUM_REGS    = 8;
    localparam int REG_SEL_W   = 3;
    localparam int CFG_ADDR_W  = 4;
    localparam int IDX_W       = 4;
    localparam int BOUND_W     = 32;
    localparam int SAMPLE_W    = 32;
    localparam int OUT_CNT_W   = 32;
    localparam int SUM_W       = 48;

    localparam logic [BOUND_W-1:0] RESET_BOUNDS [NUM_REGS] = '{
        32'd1000, 32'd5000, 32'd10000, 32'd25000,
        32'd50000, 32'd100000, 32'd250000, 32'd500000
    };

    typedef enum logic [0:0] {
        OP_OBSERVE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef struct packed {
        logic                valid;
        t_op                 op;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    idx;
    } t_obs;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_commit;

    typedef struct packed {
        logic                   valid;
        logic [COUNT_WIDTH-1:0] cum;
    } t_token;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [COUNT_WIDTH-1:0] b
    );
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, v};
        return (|ext[COUNT_WIDTH+OUT_CNT_W-1:OUT_CNT_W]) ? {OUT_CNT_W{1'b1}}
                                                         : ext[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/lbh_cell.sv
// ----------------------------------------------------------------------------
// Histogram bucket cell
// Holds one bound and one bucket count; compares a passing sample against
// the bound, counts committed hits and adds its count to a passing readout.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lbh_pkg::IDX_W-1:0]         i_index,
    input  logic                              i_tail,
    input  logic                              i_cfg_we,
    input  logic [lbh_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [lbh_pkg::BOUND_W-1:0]       i_cfg_data,
    input  lbh_pkg::t_obs                     i_obs,
    output lbh_pkg::t_obs                     o_obs,
    input  lbh_pkg::t_commit                  i_commit,
    input  lbh_pkg::t_token                   i_tok,
    output lbh_pkg::t_token                   o_tok,
    output logic [lbh_pkg::BOUND_W-1:0]       o_bound
);
    import lbh_pkg::*;

    logic [BOUND_W-1:0]     r_bound;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    t_obs                   r_obs;
    t_obs                   n_obs;
    t_token                 r_tok;
    t_token                 n_tok;
    logic                   hit;

    assign hit = !i_tail && (r_bound <= i_obs.sample);

    always_comb begin
        n_obs     = i_obs;
        n_obs.idx = i_obs.idx + IDX_W'(hit);
        n_tok.valid = i_tok.valid;
        n_tok.cum   = sat_add(i_tok.cum, r_count);
        n_count = r_count;
        if (i_commit.valid && i_commit.idx == i_index) begin
            n_count = sat_add(r_count, COUNT_WIDTH'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= i_tail ? '0 : RESET_BOUNDS[i_index[REG_SEL_W-1:0]];
            r_count     <= '0;
            r_obs.valid <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_cfg_we && !i_tail && i_cfg_addr == CFG_ADDR_W'(i_index)) begin
                r_bound <= i_cfg_data;
            end
            r_count <= n_count;
            r_obs   <= n_obs;
            r_tok   <= n_tok;
        end
    end

    assign o_obs   = r_obs;
    assign o_tok   = r_tok;
    assign o_bound = r_bound;

endmodule

`default_nettype wire

>>> hdl/latency_bucket_histogram.sv
// ----------------------------------------------------------------------------
// Latency bucket histogram
// Cumulative bucket histogram of microsecond latency samples built as a
// chain of bucket cells.
// ----------------------------------------------------------------------------
// Observe beats are taken one per cycle while o_busy is low; each sample
// walks the chain of NUM_BUCKETS cells, one cell a cycle, gathering its
// bucket index, and the bucket count is bumped as it leaves the chain. Total
// count and sum update at once. A read beat raises o_busy, follows the
// in-flight samples down the compare chain, then a readout token walks the
// cells, so the NUM_BUCKETS results appear in bucket order without gaps,
// each on the ports for one cycle with o_strobe high. The receiver cannot
// stall. o_busy drops as the last result is shown, and the next beat is
// taken once o_busy is low again.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_bucket_histogram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_opcode,
    input  logic [lbh_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_cfg_we,
    input  logic [lbh_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lbh_pkg::BOUND_W-1:0]    i_cfg_data,
    output logic                           o_strobe,
    output logic [lbh_pkg::IDX_W-1:0]      o_bucket_index,
    output logic [lbh_pkg::BOUND_W-1:0]    o_bucket_bound,
    output logic                           o_bound_infinite,
    output logic [lbh_pkg::OUT_CNT_W-1:0]  o_cumulative_count,
    output logic [lbh_pkg::OUT_CNT_W-1:0]  o_total_count,
    output logic [lbh_pkg::SUM_W-1:0]      o_total_sum,
    output logic                           o_last_bucket
);
    import lbh_pkg::*;

    t_obs                   obs_chain [NUM_BUCKETS+1];
    t_token                 tok_chain [NUM_BUCKETS+1];
    logic [BOUND_W-1:0]     bound_of  [NUM_BUCKETS];
    t_commit                commit;

    logic                   accept;
    logic                   r_busy;
    logic                   n_busy;
    logic [COUNT_WIDTH-1:0] r_sample_count;
    logic [SUM_W-1:0]       r_sample_sum;
    logic [SUM_W:0]         sum_ext;

    logic                   sel_valid;
    logic [IDX_W-1:0]       sel_index;
    logic [BOUND_W-1:0]     sel_bound;
    logic                   sel_inf;
    logic [COUNT_WIDTH-1:0] sel_cum;

    logic                   r_strobe;
    logic [IDX_W-1:0]       r_index;
    logic [BOUND_W-1:0]     r_bound;
    logic                   r_inf;
    logic [OUT_CNT_W-1:0]   r_cum;
    logic [OUT_CNT_W-1:0]   r_total;
    logic [SUM_W-1:0]       r_sum;

    assign accept = i_start && !r_busy;

    always_comb begin
        obs_chain[0].valid  = accept;
        obs_chain[0].op     = t_op'(i_opcode);
        obs_chain[0].sample = i_sample;
        obs_chain[0].idx    = '0;
        commit.valid = obs_chain[NUM_BUCKETS].valid && obs_chain[NUM_BUCKETS].op == OP_OBSERVE;
        commit.idx   = obs_chain[NUM_BUCKETS].idx;
        tok_chain[0].valid = obs_chain[NUM_BUCKETS].valid
                             && obs_chain[NUM_BUCKETS].op == OP_READ;
        tok_chain[0].cum   = '0;
    end

    for (genvar k = 0; k < NUM_BUCKETS; k++) begin : g_cell
        lbh_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (IDX_W'(k)),
            .i_tail     (k == NUM_BOUNDS),
            .i_cfg_we   (i_cfg_we),
            .i_cfg_addr (i_cfg_addr),
            .i_cfg_data (i_cfg_data),
            .i_obs      (obs_chain[k]),
            .o_obs      (obs_chain[k+1]),
            .i_commit   (commit),
            .i_tok      (tok_chain[k]),
            .o_tok      (tok_chain[k+1]),
            .o_bound    (bound_of[k])
        );
    end

    always_comb begin
        n_busy = r_busy;
        if (accept && t_op'(i_opcode) == OP_READ) begin
            n_busy = 1'b1;
        end else if (tok_chain[NUM_BUCKETS].valid) begin
            n_busy = 1'b0;
        end
        sum_ext = {1'b0, r_sample_sum} + (SUM_W+1)'(i_sample);
    end

    always_comb begin
        sel_valid = 1'b0;
        sel_index = '0;
        sel_bound = '0;
        sel_inf   = 1'b0;
        sel_cum   = '0;
        for (int k = 0; k < NUM_BUCKETS; k++) begin
            if (tok_chain[k+1].valid) begin
                sel_valid = 1'b1;
                sel_index = IDX_W'(k);
                sel_bound = bound_of[k];
                sel_inf   = (k == NUM_BOUNDS);
                sel_cum   = tok_chain[k+1].cum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_sample_count <= '0;
            r_sample_sum   <= '0;
            r_strobe       <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (accept && t_op'(i_opcode) == OP_OBSERVE) begin
                r_sample_count <= sat_add(r_sample_count, COUNT_WIDTH'(1));
                r_sample_sum   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            end
            r_strobe <= sel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= sel_index;
        r_bound <= sel_bound;
        r_inf   <= sel_inf;
        r_cum   <= clamp_out(sel_cum);
        r_total <= clamp_out(r_sample_count);
        r_sum   <= r_sample_sum;
    end

    assign o_busy             = r_busy;
    assign o_strobe           = r_strobe;
    assign o_bucket_index     = r_index;
    assign o_bucket_bound     = r_bound;
    assign o_bound_infinite   = r_inf;
    assign o_cumulative_count = r_cum;
    assign o_total_count      = r_total;
    assign o_total_sum        = r_sum;
    assign o_last_bucket      = r_inf;

endmodule

`default_nettype wire

>>> hdl/lbh_checker.sv
// ----------------------------------------------------------------------------
// Latency bucket histogram checker
// Port-level checks on readout sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "latency_bucket_histogram_assert.svh"

module lbh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           o_busy,
    input  logic                           i_opcode,
    input  logic                           o_strobe,
    input  logic [lbh_pkg::IDX_W-1:0]      o_bucket_index,
    input  logic                           o_bound_infinite,
    input  logic [lbh_pkg::OUT_CNT_W-1:0]  o_cumulative_count,
    input  logic                           o_last_bucket
);
    import lbh_pkg::*;

    `LBH_ASSERT_NEXT(a_read_sets_busy, i_start && !o_busy && i_opcode == OP_READ, o_busy)
    `LBH_ASSERT_NEXT(a_beats_contiguous, o_strobe && !o_last_bucket, o_strobe)
    `LBH_ASSERT_NEXT(a_index_advances, o_strobe && !o_last_bucket, o_bucket_index == $past(o_bucket_index) + IDX_W'(1))
    `LBH_ASSERT_NOW(a_last_is_overflow, o_strobe && o_last_bucket, o_bound_infinite && o_bucket_index == IDX_W'(NUM_BOUNDS))
    `LBH_ASSERT_NEXT(a_cum_monotonic, o_strobe && !o_last_bucket, o_cumulative_count >= $past(o_cumulative_count))

endmodule

bind latency_bucket_histogram lbh_checker u_lbh_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Latency bucket histogram testbench
// Drives observe and read beats through the start/busy handshake and keeps
// its own copy of the bounds, bucket counts, sample count and sample sum.
// Every read beat queues the nine expected bucket rows. Each strobed result
// is checked field by field against the oldest queued row. Directed beats
// cover bound edges, unsorted and equal bounds, and ignored register
// indexes. Random phases vary the bounds and the sender idling. A final
// phase sends a short run of maximum samples followed by mixed beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lbh_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]     idx;
        logic [BOUND_W-1:0]   bound;
        logic                 inf;
        logic [OUT_CNT_W-1:0] cum;
        logic [OUT_CNT_W-1:0] total;
        logic [SUM_W-1:0]     acc_sum;
        logic                 last_flag;
    } t_bucket_row;

    localparam int               DRAIN_CYCLES = 2 * NUM_BUCKETS + 4;
    localparam logic [31:0]      MAX32        = 32'hFFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MAX      = '1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    logic                  i_opcode   = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample   = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [BOUND_W-1:0]    i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_strobe;
    logic [IDX_W-1:0]      o_bucket_index;
    logic [BOUND_W-1:0]    o_bucket_bound;
    logic                  o_bound_infinite;
    logic [OUT_CNT_W-1:0]  o_cumulative_count;
    logic [OUT_CNT_W-1:0]  o_total_count;
    logic [SUM_W-1:0]      o_total_sum;
    logic                  o_last_bucket;

    logic [BOUND_W-1:0]     bound_regs [NUM_REGS];
    logic [COUNT_WIDTH-1:0] bucket_hits [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] sample_total;
    logic [SUM_W-1:0]       sample_sum_acc;
    t_bucket_row            readout_q [$];
    int                     mismatches = 0;
    int                     idle_pct   = 0;

    latency_bucket_histogram uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_opcode           (i_opcode),
        .i_sample           (i_sample),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_bucket_index     (o_bucket_index),
        .o_bucket_bound     (o_bucket_bound),
        .o_bound_infinite   (o_bound_infinite),
        .o_cumulative_count (o_cumulative_count),
        .o_total_count      (o_total_count),
        .o_total_sum        (o_total_sum),
        .o_last_bucket      (o_last_bucket)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 1000000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic record_sample(input logic [SAMPLE_W-1:0] smp);
        int             slot;
        logic [SUM_W:0] s;
        slot = 0;
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            if (bound_regs[i] <= smp) slot++;
        end
        if (bucket_hits[slot] != '1) bucket_hits[slot] = bucket_hits[slot] + 1'b1;
        if (sample_total != '1) sample_total = sample_total + 1'b1;
        s = {1'b0, sample_sum_acc} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, smp};
        sample_sum_acc = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endtask

    task automatic queue_readout();
        t_bucket_row          row;
        logic [COUNT_WIDTH:0] run;
        run = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            run = run + {1'b0, bucket_hits[i]};
            if (run[COUNT_WIDTH]) run = {1'b0, {COUNT_WIDTH{1'b1}}};
            row.idx = IDX_W'(i);
            row.inf = (i == NUM_BOUNDS);
            if (i < NUM_BOUNDS) row.bound = bound_regs[i];
            else row.bound = '0;
            row.cum = run[OUT_CNT_W-1:0];
            row.total = sample_total;
            row.acc_sum = sample_sum_acc;
            row.last_flag = row.inf;
            readout_q.push_back(row);
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_bucket_row want;
        if (i_rst_n && o_strobe) begin
            if (readout_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual bucket %0d",
                         $time, o_bucket_index);
                mismatches++;
            end else begin
                want = readout_q.pop_front();
                check_field("bucket_index", SUM_W'(want.idx), SUM_W'(o_bucket_index));
                check_field("bucket_bound", SUM_W'(want.bound), SUM_W'(o_bucket_bound));
                check_field("bound_infinite", SUM_W'(want.inf), SUM_W'(o_bound_infinite));
                check_field("cumulative_count", SUM_W'(want.cum),
                            SUM_W'(o_cumulative_count));
                check_field("total_count", SUM_W'(want.total), SUM_W'(o_total_count));
                check_field("total_sum", want.acc_sum, o_total_sum);
                check_field("last_bucket", SUM_W'(want.last_flag), SUM_W'(o_last_bucket));
            end
        end
    end

    task automatic send_item(input t_op op, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start  <= 1'b1;
        i_opcode <= op;
        i_sample <= smp;
        do @(posedge i_clk); while (o_busy);
        if (op == OP_READ) queue_readout();
        else record_sample(smp);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (readout_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [BOUND_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr < NUM_REGS) bound_regs[addr] = data;
    endtask

    task automatic load_ascending(input logic [BOUND_W-1:0] span);
        logic [BOUND_W-1:0] b;
        b = $urandom_range(0, span);
        for (int i = 0; i < NUM_REGS; i++) begin
            write_cfg(CFG_ADDR_W'(i), b);
            b = b + $urandom_range(1, span);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] b;
        b = bound_regs[$urandom_range(0, NUM_BOUNDS - 1)];
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return b + $urandom_range(0, 2) - 1;
            2: return $urandom_range(0, 1) ? MAX32 : '0;
            3: return $urandom_range(0, 2000);
            default: return $urandom_range(0, b);
        endcase
    endfunction

    task automatic test_default_bounds();
        idle_pct = 0;
        send_item(OP_OBSERVE, 32'd0);
        send_item(OP_OBSERVE, 32'd999);
        send_item(OP_OBSERVE, 32'd1000);
        send_item(OP_OBSERVE, 32'd1001);
        send_item(OP_OBSERVE, 32'd250000);
        send_item(OP_OBSERVE, 32'd500000);
        send_item(OP_OBSERVE, MAX32);
        send_item(OP_READ, MAX32);
        send_item(OP_READ, 32'd0);
    endtask

    task automatic test_odd_bounds();
        settle();
        write_cfg(0, 32'd0);
        write_cfg(1, MAX32);
        write_cfg(2, 32'd7);
        write_cfg(3, 32'd7);
        write_cfg(4, 32'd100);
        write_cfg(5, 32'd3);
        write_cfg(6, 32'h8000_0000);
        write_cfg(7, MAX32);
        write_cfg(8, 32'd1);
        write_cfg(15, MAX32);
        send_item(OP_OBSERVE, 32'd0);
        send_item(OP_OBSERVE, 32'd3);
        send_item(OP_OBSERVE, 32'd6);
        send_item(OP_OBSERVE, 32'd7);
        send_item(OP_OBSERVE, 32'h7FFF_FFFF);
        send_item(OP_OBSERVE, 32'h8000_0000);
        send_item(OP_OBSERVE, MAX32);
        send_item(OP_READ, 32'h5555_AAAA);
    endtask

    task automatic test_random_phases();
        int pct_by_phase [4] = '{0, 82, 0, 10};
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: load_ascending(32'h0000_FFFF);
                1: load_ascending(32'h1FFF_FFFF);
                2: begin
                    write_cfg(0, 32'd0);
                    write_cfg(1, 32'd0);
                    write_cfg(2, 32'd1);
                    write_cfg(3, 32'd1);
                    write_cfg(4, MAX32 - 1);
                    write_cfg(5, MAX32 - 1);
                    write_cfg(6, MAX32);
                    write_cfg(7, MAX32);
                end
                default: begin
                    for (int i = 0; i < NUM_REGS; i++) write_cfg(CFG_ADDR_W'(i), $urandom);
                end
            endcase
            write_cfg(CFG_ADDR_W'($urandom_range(NUM_REGS, 15)), $urandom);
            idle_pct = pct_by_phase[phase];
            repeat (80) begin
                send_item(($urandom_range(0, 9) == 0) ? OP_READ : OP_OBSERVE, pick_sample());
            end
        end
    endtask

    task automatic test_max_samples();
        settle();
        load_ascending(32'h0FFF_FFFF);
        idle_pct = 0;
        repeat (6) send_item(OP_OBSERVE, MAX32);
        send_item(OP_READ, 32'd0);
        idle_pct = 10;
        repeat (12) begin
            send_item(($urandom_range(0, 3) == 0) ? OP_READ : OP_OBSERVE, pick_sample());
        end
        send_item(OP_READ, 32'd0);
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) bound_regs[i] = RESET_BOUNDS[i];
        for (int i = 0; i < NUM_BUCKETS; i++) bucket_hits[i] = '0;
        sample_total   = '0;
        sample_sum_acc = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_bounds();
        test_odd_bounds();
        test_random_phases();
        test_max_samples();
        settle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
